// ===== hdl/bmf_pkg.sv =====
// Shared constants, types and register codes of the box mean filter.
package bmf_pkg;

  localparam int PIX_W     = 8;   // pixel and result width
  localparam int KSZ_W     = 3;   // kernel side register width
  localparam int DIM_W     = 11;  // image_width / image_height register width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam int DEF_MAX_KERNEL = 7;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [KSZ_W-1:0] RST_KERNEL = 3'd3;
  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FLUSH,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } bmf_state_t;

endpackage

// ===== hdl/bmf_store.sv =====
// Pixel row store: one write port, one registered read port.
module bmf_store #(
  parameter int DEPTH = 7168,
  parameter int AW    = 13
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [bmf_pkg::PIX_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic [bmf_pkg::PIX_W-1:0] rd_data
);
  import bmf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/bmf_div.sv =====
// Restoring divider: one quotient bit per cycle, quotient known to fit PIX_W bits.
module bmf_div #(
  parameter int NW = 14,
  parameter int DW = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NW-1:0]             dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [bmf_pkg::PIX_W-1:0] quot
);
  import bmf_pkg::*;

  localparam int TW = NW + DW + PIX_W;
  localparam int CW = $clog2(PIX_W + 1);

  logic [TW-1:0]    rem_r, rem_nxt;
  logic [TW-1:0]    dsh_r, dsh_nxt;
  logic [PIX_W-1:0] q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = TW'(dividend);
      dsh_nxt  = TW'(divisor) << (PIX_W - 1);
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract, shift divisor down
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[PIX_W-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[PIX_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(PIX_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== hdl/box_mean_filter.sv =====
// Top level of the streaming 2-D box (mean) filter for 8-bit grayscale frames.
//
//  channel | direction | transaction content
//  --------+-----------+------------------------------------------------
//  in_     | slave     | tdata = pixel, tuser = drain flag
//  out_    | master    | tdata = filtered mean, tlast = frame end
//  cfg_    | slave     | cfg_index selects register, cfg_data its value
//
//  An input transaction that releases no result ends after the readiness check.
//  One that releases a result reads its k*k window (k = effective kernel side)
//  one pixel per cycle through the single read port of the row store, then a
//  restoring divider forms the quotient; in_tready stays low until it is done.
//  The output register parts the two sides; a stalled out_tready holds only a
//  transaction that has its own result waiting. Reset (rst_n, synchronous,
//  active low) clears positions and registers; the store is not cleared.
//  Any register write restarts the frame.
module box_mean_filter #(
  parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bmf_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel
  input  logic                          in_tuser,   // [0] drain
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bmf_pkg::PIX_W-1:0]     out_tdata,  // [7:0] filtered
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import bmf_pkg::*;

  localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + MAX_KERNEL + 1);
  localparam int LW    = $clog2((MAX_HEIGHT + MAX_KERNEL) * MAX_WIDTH + 1);
  localparam int SW    = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int KKW   = 2 * KW;

  // Configuration registers and their effective values
  logic [KSZ_W-1:0] kernel_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [KW-1:0]    k;
  logic [XW-1:0]    w;
  logic [HW-1:0]    h;
  logic [KW-1:0]    lead, after;

  always_comb begin
    if (kernel_r == '0) k = KW'(1);
    else if (32'(kernel_r) > 32'(MAX_KERNEL)) k = KW'(MAX_KERNEL);
    else k = KW'(kernel_r);
    if (width_r == '0) w = XW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) w = XW'(MAX_WIDTH);
    else w = XW'(width_r);
    if (height_r == '0) h = HW'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else h = HW'(height_r);
  end

  assign lead  = (k - KW'(1)) >> 1;
  assign after = k >> 1;

  bmf_state_t st_r, st_nxt;

  // Positions and address trackers
  logic [YW-1:0] in_row_r;
  logic [XW-1:0] in_col_r;
  logic [LW-1:0] in_lin_r, last_lin_r;
  logic [AW-1:0] wr_addr_r, base_addr_r;
  logic [YW-1:0] out_row_r;
  logic [XW-1:0] out_col_r;

  // Window walk
  logic [KW-1:0]        dx_r, dy_r;
  logic signed [YW:0]   x_r;
  logic signed [XW:0]   y_r, y0;
  logic [AW-1:0]        row_addr_r, cell_addr_r;
  logic [SW-1:0]        sum_r;
  logic                 rd_vld_r;

  // Registered products, refreshed every cycle
  logic [LW-1:0]        need_prod_r;
  logic [KW+XW-1:0]     bw_r;

  logic                 cfg_wr, in_acc, stuck, row_ok, last_cell, in_bounds;
  logic [YW-1:0]        row_lim, need_row;
  logic [XW:0]          need_col_raw;
  logic [XW-1:0]        need_col;
  logic [LW-1:0]        need_lin;
  logic [YW+XW-1:0]     need_prod;
  logic [AW:0]          start_sum, start_addr, row_step, row_next;
  logic [AW-1:0]        cell_next;
  logic                 frame_last;

  logic                 store_we;
  logic [PIX_W-1:0]     rd_data;
  logic                 div_start, div_done;
  logic [PIX_W-1:0]     quot;

  logic                 out_tvalid_r;
  logic [PIX_W-1:0]     out_tdata_r;
  logic                 out_tlast_r;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && (cfg_index != CFG_NONE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign row_lim = YW'(h) + YW'(MAX_KERNEL);
  assign stuck   = in_row_r >= row_lim;
  assign row_ok  = in_row_r < YW'(h);

  // Readiness test: the last pixel the window needs must have arrived
  assign need_row     = out_row_r + YW'(after);
  assign need_prod    = need_row * w;
  assign need_col_raw = {1'b0, out_col_r} + (XW+1)'(after);
  assign need_col     = (need_col_raw > (XW+1)'(w - XW'(1))) ? (w - XW'(1))
                                                              : need_col_raw[XW-1:0];
  assign need_lin     = need_prod_r + LW'(need_col);

  always_ff @(posedge clk) begin
    need_prod_r <= LW'(need_prod);
    bw_r        <= lead * w;
  end

  // Window top-left address: base - (lead*w + lead), modulo the store depth
  assign start_sum  = {1'b0, base_addr_r} + (AW+1)'(DEPTH) - (AW+1)'(bw_r + (KW+XW)'(lead));
  assign start_addr = (start_sum >= (AW+1)'(DEPTH)) ? start_sum - (AW+1)'(DEPTH) : start_sum;
  assign row_step   = {1'b0, row_addr_r} + (AW+1)'(w);
  assign row_next   = (row_step >= (AW+1)'(DEPTH)) ? row_step - (AW+1)'(DEPTH) : row_step;
  assign cell_next  = (cell_addr_r == AW'(DEPTH - 1)) ? '0 : cell_addr_r + AW'(1);

  assign y0        = $signed({1'b0, out_col_r}) - $signed((XW+1)'(lead));
  assign last_cell = (dx_r == k - KW'(1)) && (dy_r == k - KW'(1));
  assign in_bounds = !x_r[YW] && (x_r[YW-1:0] < YW'(h)) &&
                     !y_r[XW] && (y_r[XW-1:0] < w);

  assign frame_last = (out_row_r >= YW'(h) - YW'(1)) && (out_col_r >= w - XW'(1));

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_acc) st_nxt = ST_CHECK;
      ST_CHECK:  st_nxt = (last_lin_r >= need_lin) ? ST_READ : ST_IDLE;
      ST_READ:   if (last_cell) st_nxt = ST_FLUSH;
      ST_FLUSH:  st_nxt = ST_DSTART;
      ST_DSTART: st_nxt = ST_DWAIT;
      ST_DWAIT:  if (div_done) st_nxt = ST_OUT;
      ST_OUT:    if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    store_we  = (st_r == ST_IDLE) && in_tvalid && row_ok;
    div_start = (st_r == ST_DSTART);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Configuration and position tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r    <= RST_KERNEL;
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_lin_r    <= '0;
      wr_addr_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      base_addr_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KERNEL: kernel_r <= cfg_data[KSZ_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default:    kernel_r <= kernel_r;
      endcase
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_lin_r    <= '0;
      wr_addr_r   <= '0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      base_addr_r <= '0;
    end else begin
      if (in_acc && !stuck) begin
        // advance the input position
        in_lin_r  <= in_lin_r + LW'(1);
        wr_addr_r <= (wr_addr_r == AW'(DEPTH - 1)) ? '0 : wr_addr_r + AW'(1);
        if (in_col_r + XW'(1) >= w) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + YW'(1);
        end else begin
          in_col_r <= in_col_r + XW'(1);
        end
      end
      if (st_r == ST_OUT && out_free) begin
        if (frame_last) begin
          // frame done: restart every position
          in_row_r    <= '0;
          in_col_r    <= '0;
          in_lin_r    <= '0;
          wr_addr_r   <= '0;
          out_row_r   <= '0;
          out_col_r   <= '0;
          base_addr_r <= '0;
        end else begin
          base_addr_r <= (base_addr_r == AW'(DEPTH - 1)) ? '0 : base_addr_r + AW'(1);
          if (out_col_r + XW'(1) >= w) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + YW'(1);
          end else begin
            out_col_r <= out_col_r + XW'(1);
          end
        end
      end
    end
  end

  // Window walk: one store read per cycle, accumulate in the cycle after
  always_ff @(posedge clk) begin
    if (in_acc) begin
      last_lin_r <= in_lin_r;
    end
    if (st_r == ST_CHECK) begin
      dx_r        <= '0;
      dy_r        <= '0;
      x_r         <= $signed({1'b0, out_row_r}) - $signed((YW+1)'(lead));
      y_r         <= y0;
      row_addr_r  <= start_addr[AW-1:0];
      cell_addr_r <= start_addr[AW-1:0];
      sum_r       <= '0;
    end else begin
      if (st_r == ST_READ) begin
        if (dy_r == k - KW'(1)) begin
          dy_r        <= '0;
          dx_r        <= dx_r + KW'(1);
          x_r         <= x_r + (YW+1)'(1);
          y_r         <= y0;
          row_addr_r  <= row_next[AW-1:0];
          cell_addr_r <= row_next[AW-1:0];
        end else begin
          dy_r        <= dy_r + KW'(1);
          y_r         <= y_r + (XW+1)'(1);
          cell_addr_r <= cell_next;
        end
      end
      if (rd_vld_r) begin
        sum_r <= sum_r + SW'(rd_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (st_r == ST_READ) && in_bounds;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (st_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && out_free) begin
      out_tdata_r <= quot;
      out_tlast_r <= frame_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  bmf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (wr_addr_r),
    .wr_data (in_tuser ? '0 : in_tdata),
    .rd_addr (cell_addr_r),
    .rd_data (rd_data)
  );

  bmf_div #(
    .NW (SW),
    .DW (KKW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (KKW'(k) * KKW'(k)),
    .done     (div_done),
    .quot     (quot)
  );

endmodule
